@@ hw/rtl/pmflru_pkg.sv @@
// Shared types and constants for the paged memory replacement core.
package pmflru_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 6;
	localparam int unsigned FRAME_OUT_W = 2;
	localparam int unsigned PAGE_OUT_W = 3;

	// Memory geometry
	localparam int unsigned NUM_FRAMES = 4;
	localparam int unsigned NUM_PAGES  = 8;
	localparam int unsigned PAGE_WORDS = 8;

	// Access kinds
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Replacement policy codes
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	typedef struct packed {
		logic                     req_type;
		logic [ADDR_W-1:0]        address;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic                     page_fault;
		logic [FRAME_OUT_W-1:0]   frame_used;
		logic                     evicted;
		logic [PAGE_OUT_W-1:0]    victim_page;
		logic                     writeback;
	} rsp_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic show;
	} ctrl_cmd_t;

endpackage

@@ hw/rtl/pmflru_ctrl.sv @@
// Sequencing state machine: accept, execute, present one result.
module pmflru_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	output pmflru_pkg::ctrl_cmd_t cmd
);
	import pmflru_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Decode next state and commands
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		cmd.show = 1'b0;
		busy     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// Show the result and take the next transaction at once
				busy     = 1'b0;
				cmd.show = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign done = cmd.show;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/pmflru_dp.sv @@
// Datapath: frame table, page flags, replacement ages and page word memory.
module pmflru_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pmflru_pkg::ctrl_cmd_t cmd,
	input  pmflru_pkg::req_t      req,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	output pmflru_pkg::rsp_t      result
);
	import pmflru_pkg::*;

	localparam int unsigned FR_W   = $clog2(NUM_FRAMES);
	localparam int unsigned VPN_W  = $clog2(NUM_PAGES);
	localparam int unsigned OFF_W  = $clog2(PAGE_WORDS);
	localparam int unsigned AGE_W  = $clog2(NUM_FRAMES + 1);
	localparam int unsigned MEM_D  = NUM_PAGES * PAGE_WORDS;
	localparam int unsigned MEM_AW = $clog2(MEM_D);

	// Registered state
	req_t                     req_q;
	logic                     use_lru_q;
	logic [NUM_FRAMES-1:0]    occ_q;
	logic [VPN_W-1:0]         fpage_q [NUM_FRAMES];
	logic [AGE_W-1:0]         fifo_q  [NUM_FRAMES];
	logic [AGE_W-1:0]         lru_q   [NUM_FRAMES];
	logic [NUM_PAGES-1:0]     res_q;
	logic [NUM_PAGES-1:0]     dirty_q;
	logic [MEM_D-1:0]         wvalid_q;
	logic signed [DATA_W-1:0] mem [MEM_D];

	// Result registers
	logic signed [DATA_W-1:0] rd_q;
	logic                     rdv_q;
	logic                     fault_q;
	logic [FR_W-1:0]          frame_q;
	logic                     evict_q;
	logic [VPN_W-1:0]         victim_q;
	logic                     wb_q;

	// Lookup and update signals
	logic [OFF_W-1:0]      off;
	logic [VPN_W-1:0]      vpn;
	logic [MEM_AW-1:0]     maddr;
	logic                  hit;
	logic [FR_W-1:0]       hit_f;
	logic                  has_empty;
	logic [FR_W-1:0]       empty_f;
	logic [AGE_W-1:0]      best;
	logic [FR_W-1:0]       vict_f;
	logic [FR_W-1:0]       frame;
	logic                  fault;
	logic                  evict;
	logic [VPN_W-1:0]      victim;
	logic                  wb;
	logic [NUM_FRAMES-1:0] occ_n;
	logic [VPN_W-1:0]      fpage_n [NUM_FRAMES];
	logic [AGE_W-1:0]      fifo_n  [NUM_FRAMES];
	logic [AGE_W-1:0]      lru_n   [NUM_FRAMES];
	logic [AGE_W-1:0]      lru_touch [NUM_FRAMES];
	logic [AGE_W-1:0]      mine;
	logic [AGE_W-1:0]      sel_age;

	// Split the address into page and offset, wrap the page number
	always_comb begin
		off   = req_q.address[OFF_W-1:0];
		vpn   = VPN_W'(req_q.address >> OFF_W);
		maddr = {vpn, off};
	end

	// Search frames, pick a frame and work out the new ages
	always_comb begin
		hit       = 1'b0;
		hit_f     = '0;
		has_empty = 1'b0;
		empty_f   = '0;
		best      = '0;
		vict_f    = '0;
		sel_age   = '0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (!hit && res_q[vpn] && occ_q[i] && (fpage_q[i] == vpn)) begin
				hit   = 1'b1;
				hit_f = FR_W'(i);
			end
			if (!has_empty && !occ_q[i]) begin
				has_empty = 1'b1;
				empty_f   = FR_W'(i);
			end
			sel_age = (use_lru_q == POLICY_LRU) ? lru_q[i] : fifo_q[i];
			if (sel_age > best) begin
				best   = sel_age;
				vict_f = FR_W'(i);
			end
		end

		occ_n   = occ_q;
		fpage_n = fpage_q;
		fifo_n  = fifo_q;
		lru_n   = lru_q;
		fault   = !hit;
		evict   = 1'b0;
		victim  = '0;
		wb      = 1'b0;
		frame   = hit_f;
		if (!hit && has_empty) begin
			// Fill the lowest empty frame and age the others
			frame = empty_f;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				if (occ_q[i]) begin
					fifo_n[i] = fifo_q[i] + AGE_W'(1);
					lru_n[i]  = lru_q[i] + AGE_W'(1);
				end
			end
			occ_n[empty_f]   = 1'b1;
			fpage_n[empty_f] = vpn;
			fifo_n[empty_f]  = AGE_W'(1);
			lru_n[empty_f]   = AGE_W'(1);
		end else if (!hit) begin
			// Replace the oldest frame under the active policy
			frame  = vict_f;
			evict  = 1'b1;
			victim = fpage_q[vict_f];
			wb     = dirty_q[fpage_q[vict_f]];
			for (int i = 0; i < NUM_FRAMES; i++) begin
				if (FR_W'(i) != vict_f) begin
					if (use_lru_q == POLICY_LRU) begin
						if (lru_q[i] < AGE_W'(NUM_FRAMES))
							lru_n[i] = lru_q[i] + AGE_W'(1);
					end else begin
						if (fifo_q[i] < AGE_W'(NUM_FRAMES))
							fifo_n[i] = fifo_q[i] + AGE_W'(1);
					end
				end
			end
			if (use_lru_q == POLICY_LRU)
				lru_n[vict_f] = AGE_W'(1);
			else
				fifo_n[vict_f] = AGE_W'(1);
			fpage_n[vict_f] = vpn;
		end

		// Make the chosen frame the most recently used
		mine      = lru_n[frame];
		lru_touch = lru_n;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (occ_n[i] && (lru_n[i] < mine))
				lru_touch[i] = lru_n[i] + AGE_W'(1);
		end
		lru_touch[frame] = AGE_W'(1);
	end

	// Capture the request and the policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_lru_q <= POLICY_FIFO;
		end else if (cfg_we) begin
			use_lru_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
	end

	// Update frame table, page flags and word valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			res_q    <= '0;
			dirty_q  <= '0;
			wvalid_q <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				fpage_q[i] <= '0;
				fifo_q[i]  <= '0;
				lru_q[i]   <= '0;
			end
		end else if (cmd.exec) begin
			occ_q   <= occ_n;
			fpage_q <= fpage_n;
			fifo_q  <= fifo_n;
			lru_q   <= lru_touch;
			if (evict) begin
				res_q[victim]   <= 1'b0;
				dirty_q[victim] <= 1'b0;
			end
			if (fault)
				res_q[vpn] <= 1'b1;
			if (req_q.req_type == REQ_WRITE) begin
				dirty_q[vpn]    <= 1'b1;
				wvalid_q[maddr] <= 1'b1;
			end
		end
	end

	// Word memory: write or read one word, registered read data
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (req_q.req_type == REQ_WRITE) begin
				mem[maddr] <= req_q.write_value;
				rd_q       <= req_q.write_value;
				rdv_q      <= 1'b1;
			end else begin
				rd_q  <= mem[maddr];
				rdv_q <= wvalid_q[maddr];
			end
		end
	end

	// Hold the result fields
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			fault_q  <= fault;
			frame_q  <= frame;
			evict_q  <= evict;
			victim_q <= victim;
			wb_q     <= wb;
		end
	end

	// Drive the result; a word never written reads as all ones
	always_comb begin
		result.read_data   = rdv_q ? rd_q : '1;
		result.page_fault  = fault_q;
		result.frame_used  = FRAME_OUT_W'(frame_q);
		result.evicted     = evict_q;
		result.victim_page = PAGE_OUT_W'(victim_q);
		result.writeback   = wb_q;
	end

endmodule

@@ hw/rtl/paged_memory_fifo_lru_replacement_core.sv @@
// done is raised in the DONE state, which follows the EXEC state after the accepting edge.
// A new transaction can be taken in the done cycle, while the previous result is shown.
// Each transaction passes through the EXEC state for the frame lookup/update and word memory access.
// Reset (arst_n low) empties all frames, clears page flags and ages, selects FIFO,
// and marks every word as never written (reads return all ones).
// The receiver cannot stall: done is high for exactly one cycle per transaction.
module paged_memory_fifo_lru_replacement_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pmflru_pkg::req_t req,
	output logic             done,
	output pmflru_pkg::rsp_t result,
	input  logic             cfg_we,
	input  logic             cfg_wdata
);
	import pmflru_pkg::*;

	ctrl_cmd_t cmd;

	// Sequence each transaction
	pmflru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Frame table, ages and word memory
	pmflru_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule
